// ===== rtl/core/mmr_pkg.sv =====
// ----------------------------------------------------------------------------
// mmr_pkg
// Shared types and constants of the min-max rescaler: operation codes,
// result status codes, configuration register indexes and the job flags
// that travel from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mmr_pkg;

    // Operation carried by each input word. Code 3 is unused and ignored.
    typedef enum logic [1:0]
    {
        OP_CLEAR   = 2'd0,
        OP_SCAN    = 2'd1,
        OP_RESCALE = 2'd2
    } op_t;

    // Status reported with each rescaled pixel.
    typedef enum logic [1:0]
    {
        ST_OK         = 2'd0,
        ST_FLAT       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_BAD_TARGET = 2'd3
    } status_t;

    // Configuration register map.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 1'd1;

    // Flags of a queued rescale job.
    typedef struct packed
    {
        status_t status;
        logic    neg;
    } job_ctl_t;

endpackage : mmr_pkg

`default_nettype wire

// ===== rtl/core/mmr_in_if.sv =====
// ----------------------------------------------------------------------------
// mmr_in_if
// Request channel of the min-max rescaler: valid/ready handshake carrying an
// operation code and a signed pixel sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmr_in_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   opcode;
    logic signed [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output opcode, output pixel, input ready);
    modport sink   (input valid, input opcode, input pixel, output ready);
endinterface : mmr_in_if

`default_nettype wire

// ===== rtl/core/mmr_out_if.sv =====
// ----------------------------------------------------------------------------
// mmr_out_if
// Result channel of the min-max rescaler: valid/ready handshake carrying the
// rescaled pixel and its status code.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmr_out_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] scaled;
    logic [1:0]                   status;

    modport source (output valid, output scaled, output status, input ready);
    modport sink   (input valid, input scaled, input status, output ready);
endinterface : mmr_out_if

`default_nettype wire

// ===== rtl/core/min_max_rescale.sv =====
// ----------------------------------------------------------------------------
// min_max_rescale
// Two-pass min-max normaliser for signed pixels.
//
// The host sends request words on req (opcode, pixel). A clear word restarts
// the statistics, a scan word folds the pixel into the running minimum and
// maximum, and a rescale word yields one result word on rsp: the pixel mapped
// linearly from the scanned range onto [target_low, target_high], quotient
// truncated towards zero, saturated to PIXEL_BITS. Opcode 3 is ignored.
// Faults (target range empty, nothing scanned, flat range, in that order of
// priority) give status codes 3, 2 and 1 with target_low as the pixel.
//
// Clear and scan words are handled in the front end alone. A rescale job is
// queued and then occupies the back end through its steps: load, multiply,
// a divider retiring two quotient bits per cycle, then add and saturate.
// Faulted jobs skip the arithmetic. A two-word queue lets the front end keep
// accepting while the back end works, and a stalled rsp holds only the back
// end: the front stops once the queue is full. Reset restores target_low 0,
// target_high 255 and empty statistics; configuration must be written only
// when idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_rescale
    import mmr_pkg::*;
#(
    parameter int PIXEL_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mmr_in_if.sink                     req,
    mmr_out_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [PIXEL_BITS-1:0] cfg_data
);

    localparam int JOB_W = 3 * PIXEL_BITS + $bits(job_ctl_t);

    // Configuration registers.
    logic signed [PIXEL_BITS-1:0] target_low_reg;
    logic signed [PIXEL_BITS-1:0] target_high_reg;

    // Front end to queue.
    logic                  push_valid, push_ready;
    logic [PIXEL_BITS-1:0] push_off, push_span, push_range;
    job_ctl_t              push_ctl;

    // Queue to back end.
    logic                  pop_valid, pop_ready;
    logic [JOB_W-1:0]      pop_data;
    logic [PIXEL_BITS-1:0] job_off, job_span, job_range;
    job_ctl_t              job_ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_low_reg  <= '0;
            target_high_reg <= PIXEL_BITS'(255);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_LOW:  target_low_reg  <= cfg_data;
                CFG_TARGET_HIGH: target_high_reg <= cfg_data;
                default:         target_low_reg  <= target_low_reg;
            endcase
        end
    end

    mmr_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .target_low  (target_low_reg),
        .target_high (target_high_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_off    (push_off),
        .push_span   (push_span),
        .push_range  (push_range),
        .push_ctl    (push_ctl)
    );

    mmr_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_off, push_span, push_range, push_ctl}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign {job_off, job_span, job_range, job_ctl} = pop_data;

    mmr_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (pop_valid),
        .job_ready  (pop_ready),
        .job_off    (job_off),
        .job_span   (job_span),
        .job_range  (job_range),
        .job_ctl    (job_ctl),
        .target_low (target_low_reg),
        .rsp        (rsp)
    );

`ifndef NO_ASSERTIONS
    // Every accepted rescale word must land in the queue in the same cycle.
    a_rescale_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.opcode == OP_RESCALE))
            |-> (push_valid && push_ready))
        else $error("accepted rescale word was not queued");

    // With an empty target range every result reports it and carries target_low.
    a_bad_target: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (target_low_reg >= target_high_reg))
            |-> ((rsp.status == ST_BAD_TARGET) && (rsp.scaled == target_low_reg)))
        else $error("bad target range not reported");

    // A flat range result must carry target_low.
    a_flat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_FLAT)) |-> (rsp.scaled == target_low_reg))
        else $error("flat range result differs from target_low");

    // Taking a job from the queue makes the back end busy, so it drops pop_ready.
    a_pop_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_ready && pop_valid) |=> !pop_ready)
        else $error("back end took a job while busy");
`endif

endmodule : min_max_rescale

`default_nettype wire

// ===== rtl/core/mmr_front.sv =====
// ----------------------------------------------------------------------------
// mmr_front
// Front end: accepts request words, keeps the running minimum and maximum,
// and turns each rescale request into a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mmr_front
    import mmr_pkg::*;
#(
    parameter int PIXEL_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    mmr_in_if.sink                            req,
    input  wire logic signed [PIXEL_BITS-1:0] target_low,
    input  wire logic signed [PIXEL_BITS-1:0] target_high,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output logic [PIXEL_BITS-1:0]             push_off,
    output logic [PIXEL_BITS-1:0]             push_span,
    output logic [PIXEL_BITS-1:0]             push_range,
    output job_ctl_t                          push_ctl
);

    localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

    logic signed [PIXEL_BITS-1:0] min_reg, min_next;
    logic signed [PIXEL_BITS-1:0] max_reg, max_next;
    logic                         any_reg, any_next;

    logic                         accept;
    op_t                          op;
    logic signed [PIXEL_BITS:0]   diff;
    logic signed [PIXEL_BITS:0]   mag;
    logic signed [PIXEL_BITS:0]   span_w;
    logic signed [PIXEL_BITS:0]   range_w;

    assign req.ready = push_ready;
    assign accept    = req.valid && push_ready;
    assign op        = op_t'(req.opcode);

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        any_next = any_reg;
        if (accept)
        begin
            unique case (op)
                OP_CLEAR:
                begin
                    min_next = PIX_MAX;
                    max_next = PIX_MIN;
                    any_next = 1'b0;
                end
                OP_SCAN:
                begin
                    if (req.pixel < min_reg)
                    begin
                        min_next = req.pixel;
                    end
                    if (req.pixel > max_reg)
                    begin
                        max_next = req.pixel;
                    end
                    any_next = 1'b1;
                end
                default:
                begin
                    min_next = min_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= PIX_MAX;
            max_reg <= PIX_MIN;
            any_reg <= 1'b0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            any_reg <= any_next;
        end
    end

    // Job for the back end: the distance of the pixel from the minimum and
    // its direction, the target span and the scanned range.
    assign diff    = {req.pixel[PIXEL_BITS-1], req.pixel} - {min_reg[PIXEL_BITS-1], min_reg};
    assign mag     = diff[PIXEL_BITS] ? -diff : diff;
    assign span_w  = {target_high[PIXEL_BITS-1], target_high}
                   - {target_low[PIXEL_BITS-1], target_low};
    assign range_w = {max_reg[PIXEL_BITS-1], max_reg} - {min_reg[PIXEL_BITS-1], min_reg};

    assign push_valid = req.valid && (op == OP_RESCALE);
    assign push_off   = mag[PIXEL_BITS-1:0];
    assign push_span  = span_w[PIXEL_BITS-1:0];
    assign push_range = range_w[PIXEL_BITS-1:0];

    always_comb
    begin
        push_ctl.neg = diff[PIXEL_BITS];
        if (target_low >= target_high)
        begin
            push_ctl.status = ST_BAD_TARGET;
        end
        else if (!any_reg)
        begin
            push_ctl.status = ST_EMPTY;
        end
        else if (max_reg == min_reg)
        begin
            push_ctl.status = ST_FLAT;
        end
        else
        begin
            push_ctl.status = ST_OK;
        end
    end

endmodule : mmr_front

`default_nettype wire

// ===== rtl/core/mmr_queue.sv =====
// ----------------------------------------------------------------------------
// mmr_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mmr_queue #(
    parameter int DATA_W = 50
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic [DATA_W-1:0]      pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule : mmr_queue

`default_nettype wire

// ===== rtl/core/mmr_back.sv =====
// ----------------------------------------------------------------------------
// mmr_back
// Back end: multiplies the offset by the target span, divides by the scanned
// range two quotient bits per cycle, then adds the quotient to, or subtracts
// it from, the target low value and saturates into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmr_back
    import mmr_pkg::*;
#(
    parameter int PIXEL_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         job_valid,
    output logic                              job_ready,
    input  wire logic [PIXEL_BITS-1:0]        job_off,
    input  wire logic [PIXEL_BITS-1:0]        job_span,
    input  wire logic [PIXEL_BITS-1:0]        job_range,
    input  wire job_ctl_t                     job_ctl,
    input  wire logic signed [PIXEL_BITS-1:0] target_low,
    mmr_out_if.source                         rsp
);

    localparam int PROD_W = 2 * PIXEL_BITS;
    localparam int WIDE_W = PROD_W + 2;
    localparam int CNT_W  = $clog2(PIXEL_BITS);
    localparam logic signed [WIDE_W-1:0] SAT_HI =
        WIDE_W'((64'sd1 <<< (PIXEL_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    state_t                       state_reg;
    logic [PIXEL_BITS-1:0]        off_reg, span_reg, range_reg;
    job_ctl_t                     ctl_reg;
    logic [PROD_W-1:0]            quo_reg, quo_next;
    logic [PIXEL_BITS-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         out_valid_reg;
    logic signed [PIXEL_BITS-1:0] scaled_reg;
    status_t                      status_reg;

    logic [PIXEL_BITS:0]          rem_a, rem_b, red_a, red_b;
    logic                         ge_a, ge_b;
    logic signed [WIDE_W-1:0]     low_w, quo_w, sum_w;
    logic signed [PIXEL_BITS-1:0] result;
    logic                         out_free;

    assign job_ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.scaled = scaled_reg;
    assign rsp.status = status_reg;
    assign out_free   = !out_valid_reg || rsp.ready;

    // Two restoring division steps per cycle; the dividend shifts out of the
    // top of quo_reg as quotient bits shift in at the bottom.
    always_comb
    begin
        rem_a    = {rem_reg, quo_reg[PROD_W-1]};
        ge_a     = (rem_a >= {1'b0, range_reg});
        red_a    = ge_a ? (rem_a - {1'b0, range_reg}) : rem_a;
        rem_b    = {red_a[PIXEL_BITS-1:0], quo_reg[PROD_W-2]};
        ge_b     = (rem_b >= {1'b0, range_reg});
        red_b    = ge_b ? (rem_b - {1'b0, range_reg}) : rem_b;
        rem_next = red_b[PIXEL_BITS-1:0];
        quo_next = {quo_reg[PROD_W-3:0], ge_a, ge_b};
    end

    always_comb
    begin
        low_w = WIDE_W'(target_low);
        quo_w = signed'({2'b00, quo_reg});
        sum_w = ctl_reg.neg ? (low_w - quo_w) : (low_w + quo_w);
        if (ctl_reg.status != ST_OK)
        begin
            result = target_low;
        end
        else if (sum_w > SAT_HI)
        begin
            result = SAT_HI[PIXEL_BITS-1:0];
        end
        else if (sum_w < SAT_LO)
        begin
            result = SAT_LO[PIXEL_BITS-1:0];
        end
        else
        begin
            result = sum_w[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    off_reg   <= job_off;
                    span_reg  <= job_span;
                    range_reg <= job_range;
                    ctl_reg   <= job_ctl;
                end
            end
            S_MUL:
            begin
                quo_reg <= PROD_W'(off_reg * span_reg);
                rem_reg <= '0;
            end
            S_DIV:
            begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    scaled_reg <= result;
                    status_reg <= ctl_reg.status;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result replaces the one being taken in the same cycle.
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg <= (job_ctl.status == ST_OK) ? S_MUL : S_DONE;
                    end
                end
                S_MUL:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(PIXEL_BITS - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule : mmr_back

`default_nettype wire
